// File: src/mfna_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfna_pkg: shared types of the face normal accumulator
// Request codes and the command record passed from the front to the back end.
// ----------------------------------------------------------------------------
package mfna_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_TRI   = 2'd2,
		REQ_READ  = 2'd3
	} req_kind_t;

	localparam int IDX_BITS = 10;
	localparam int CRD_BITS = 16;
	localparam int OUT_BITS = 48;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		req_kind_t                  kind;
		logic [IDX_BITS-1:0]        ia;
		logic [IDX_BITS-1:0]        ib;
		logic [IDX_BITS-1:0]        ic;
		logic signed [CRD_BITS-1:0] cx;
		logic signed [CRD_BITS-1:0] cy;
		logic signed [CRD_BITS-1:0] cz;
	} cmd_t;

endpackage

// File: src/mfna_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfna_req_if / mfna_rsp_if: valid/ready channels of the accumulator
// Request channel carries one item, response channel one read result.
// ----------------------------------------------------------------------------
interface mfna_req_if;
	import mfna_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 req_type;
	logic [IDX_BITS-1:0]        first_index;
	logic [IDX_BITS-1:0]        second_index;
	logic [IDX_BITS-1:0]        third_index;
	logic signed [CRD_BITS-1:0] coord_x;
	logic signed [CRD_BITS-1:0] coord_y;
	logic signed [CRD_BITS-1:0] coord_z;
	modport source (output valid, req_type, first_index, second_index, third_index,
		coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, req_type, first_index, second_index, third_index,
		coord_x, coord_y, coord_z, output ready);
endinterface

interface mfna_rsp_if;
	import mfna_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] normal_x;
	logic signed [OUT_BITS-1:0] normal_y;
	logic signed [OUT_BITS-1:0] normal_z;
	logic                       saturated;
	modport source (output valid, normal_x, normal_y, normal_z, saturated, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, saturated, output ready);
endinterface

// File: src/mfna_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfna_front: request intake and command queue
// Accepts request beats, decodes the kind and buffers commands for the back end.
// ----------------------------------------------------------------------------
module mfna_front
	import mfna_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mfna_req_if.sink    req,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_take
);

	cmd_t       mem_q [QUEUE_DEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign req.ready = (cnt_q != 2'(QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{kind: req_kind_t'(req.req_type), ia: req.first_index,
				ib: req.second_index, ic: req.third_index,
				cx: req.coord_x, cy: req.coord_y, cz: req.coord_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_take);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take from empty queue");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QUEUE_DEPTH) |-> !req.ready) else $error("ready while full");

endmodule

// File: src/mfna_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfna_back: vertex fetch, cross product and accumulator update
// Sequencer over a single-port vertex memory and an accumulator memory.
// ----------------------------------------------------------------------------
module mfna_back
	import mfna_pkg::*;
#(
	parameter int VERTEX_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_take,
	mfna_rsp_if.source  rsp
);

	localparam int COORD_BITS = CRD_BITS;
	localparam int ACC_BITS   = OUT_BITS;
	localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int EW = COORD_BITS + 1;
	localparam int PW = 2 * EW;
	localparam int NW = PW + 1;
	localparam int SW = ACC_BITS + 1;
	localparam int VW = 3 * COORD_BITS;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD_B, ST_RD_C, ST_EDGE, ST_MUL, ST_SUM, ST_ACC, ST_WAIT_RD,
		ST_OUT
	} state_t;

	state_t state_q;
	logic [AW:0]   clr_q;
	logic [AW-1:0] a_q, b_q, c_q;
	logic [VW-1:0] vmem [VERTEX_COUNT];
	logic [3*ACC_BITS:0] amem [VERTEX_COUNT];
	logic [VW-1:0] vrd_q;
	logic [3*ACC_BITS:0] ard_q;
	logic signed [COORD_BITS-1:0] v0x_q, v0y_q, v0z_q, v1x_q, v1y_q, v1z_q;
	logic signed [EW-1:0] ex_q, ey_q, ez_q, fx_q, fy_q, fz_q;
	logic signed [PW-1:0] p_q [6];
	logic signed [NW-1:0] nx_q, ny_q, nz_q;

	logic [AW-1:0] ia, ib, ic, vaddr, aaddr;
	logic          vwe, awe;
	logic [VW-1:0] vwd;
	logic [3*ACC_BITS:0] awd;
	logic signed [ACC_BITS-1:0] ox, oy, oz;
	logic sx, sy, sz;

	assign ia = AW'(cmd.ia);
	assign ib = AW'(cmd.ib);
	assign ic = AW'(cmd.ic);

	function automatic logic signed [ACC_BITS-1:0] sat(input logic signed [ACC_BITS-1:0] a,
			input logic signed [NW-1:0] b, output logic s);
		logic signed [SW-1:0] t;
		t = SW'(a) + SW'(b);
		s = (t[SW-1] != t[SW-2]);
		if (!s) sat = t[ACC_BITS-1:0];
		else if (t[SW-1]) sat = {1'b1, {(ACC_BITS-1){1'b0}}};
		else sat = {1'b0, {(ACC_BITS-1){1'b1}}};
	endfunction

	always_comb begin
		ox = sat(ard_q[ACC_BITS-1:0], nx_q, sx);
		oy = sat(ard_q[2*ACC_BITS-1:ACC_BITS], ny_q, sy);
		oz = sat(ard_q[3*ACC_BITS-1:2*ACC_BITS], nz_q, sz);
	end

	// Memory port control per state.
	always_comb begin
		vwe = 1'b0; awe = 1'b0; vaddr = ia; aaddr = ia; awd = '0; cmd_take = 1'b0;
		vwd = {COORD_BITS'(cmd.cz), COORD_BITS'(cmd.cy), COORD_BITS'(cmd.cx)};
		case (state_q)
			ST_CLEAR: begin
				awe = 1'b1; aaddr = clr_q[AW-1:0];
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						REQ_LOAD:  begin vwe = 1'b1; cmd_take = 1'b1; end
						REQ_CLEAR: begin awe = 1'b1; cmd_take = 1'b1; end
						REQ_TRI:   cmd_take = 1'b1;
						REQ_READ:  cmd_take = !rsp.valid;
						default: ;
					endcase
				end
			end
			ST_RD_B: vaddr = b_q;
			ST_RD_C: vaddr = c_q;
			ST_ACC: begin
				awe = 1'b1; aaddr = a_q; awd = {ard_q[3*ACC_BITS] | sx | sy | sz, oz, oy, ox};
			end
			default: aaddr = a_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vwe) vmem[vaddr] <= vwd;
		vrd_q <= vmem[vaddr];
		if (awe) amem[aaddr] <= awd;
		ard_q <= amem[aaddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			a_q <= ia; b_q <= ib; c_q <= ic;
		end
		if (state_q == ST_RD_B) begin
			v0x_q <= vrd_q[COORD_BITS-1:0];
			v0y_q <= vrd_q[2*COORD_BITS-1:COORD_BITS];
			v0z_q <= vrd_q[VW-1:2*COORD_BITS];
		end
		if (state_q == ST_RD_C) begin
			v1x_q <= vrd_q[COORD_BITS-1:0];
			v1y_q <= vrd_q[2*COORD_BITS-1:COORD_BITS];
			v1z_q <= vrd_q[VW-1:2*COORD_BITS];
		end
		if (state_q == ST_EDGE) begin
			ex_q <= EW'(v1x_q) - EW'(v0x_q);
			ey_q <= EW'(v1y_q) - EW'(v0y_q);
			ez_q <= EW'(v1z_q) - EW'(v0z_q);
			fx_q <= EW'($signed(vrd_q[COORD_BITS-1:0])) - EW'(v0x_q);
			fy_q <= EW'($signed(vrd_q[2*COORD_BITS-1:COORD_BITS])) - EW'(v0y_q);
			fz_q <= EW'($signed(vrd_q[VW-1:2*COORD_BITS])) - EW'(v0z_q);
		end
		if (state_q == ST_MUL) begin
			p_q[0] <= ey_q * fz_q; p_q[1] <= ez_q * fy_q;
			p_q[2] <= ez_q * fx_q; p_q[3] <= ex_q * fz_q;
			p_q[4] <= ex_q * fy_q; p_q[5] <= ey_q * fx_q;
		end
		if (state_q == ST_SUM) begin
			nx_q <= NW'(p_q[0]) - NW'(p_q[1]);
			ny_q <= NW'(p_q[2]) - NW'(p_q[3]);
			nz_q <= NW'(p_q[4]) - NW'(p_q[5]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			rsp.valid <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(VERTEX_COUNT - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_take && cmd.kind == REQ_TRI) state_q <= ST_RD_B;
					if (cmd_take && cmd.kind == REQ_READ) state_q <= ST_WAIT_RD;
				end
				ST_RD_B: state_q <= ST_RD_C;
				ST_RD_C: state_q <= ST_EDGE;
				ST_EDGE: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_IDLE;
				ST_WAIT_RD: state_q <= ST_OUT;
				ST_OUT: begin
					rsp.valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			rsp.normal_x  <= OUT_BITS'(ard_q[ACC_BITS-1:0]);
			rsp.normal_y  <= OUT_BITS'(ard_q[2*ACC_BITS-1:ACC_BITS]);
			rsp.normal_z  <= OUT_BITS'(ard_q[3*ACC_BITS-1:2*ACC_BITS]);
			rsp.saturated <= ard_q[3*ACC_BITS];
		end
	end

	a_clear_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !cmd_take) else $error("command taken during clear");
	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take && cmd.kind == REQ_READ |-> !rsp.valid) else $error("result overwritten");
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> rsp.valid) else $error("read result lost");

endmodule

// File: src/mesh_face_normal_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_face_normal_accumulator_unit: fixed-point face normal accumulator
// Channel  | dir | content
// req      | in  | request beat: kind, three indices, Q7.8 coordinates
// rsp      | out | read result: three 48-bit sums and the saturation flag
// Load and clear complete in the idle state; a triangle runs three vertex reads on
// the single vertex port, edge subtract, multiply, subtract, accumulator write.
// After reset the accumulator memory is cleared.
// A two-entry queue lets requests arrive while the sequencer is busy.
// ----------------------------------------------------------------------------
module mesh_face_normal_accumulator_unit
	import mfna_pkg::*;
#(
	parameter int VERTEX_COUNT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	mfna_req_if.sink   req,
	mfna_rsp_if.source rsp
);

	cmd_t cmd;
	logic cmd_valid, cmd_take;

	mfna_front u_front (.clk, .arst_n, .req, .cmd, .cmd_valid, .cmd_take);

	mfna_back #(.VERTEX_COUNT(VERTEX_COUNT))
		u_back (.clk, .arst_n, .cmd, .cmd_valid, .cmd_take, .rsp);

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the face normal accumulator
// Drives load, clear, triangle and read beats with random idling on both
// channels, predicts every read result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench
	import mfna_pkg::*;
();

	localparam int NVERT = 1024;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [47:0] nx;
		logic signed [47:0] ny;
		logic signed [47:0] nz;
		logic               sat;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mfna_req_if req ();
	mfna_rsp_if rsp ();

	mesh_face_normal_accumulator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic signed [15:0] vx [NVERT];
	logic signed [15:0] vy [NVERT];
	logic signed [15:0] vz [NVERT];
	logic               vloaded [NVERT];
	logic signed [47:0] ax [NVERT];
	logic signed [47:0] ay [NVERT];
	logic signed [47:0] az [NVERT];
	logic               asat [NVERT];

	cmd_t    pending_beats [$];
	normal_t expected_normals [$];
	int      send_idle_pct = 27;
	int      recv_idle_pct = 61;
	int      hold_off = 0;
	int      errors = 0;
	int      quiet_cycles = 0;

	function automatic logic signed [47:0] clamp_add(input logic signed [47:0] acc,
			input logic signed [63:0] delta, inout logic sat);
		logic signed [63:0] sum;
		sum = 64'(acc) + delta;
		if (sum > 64'sh0000_7FFF_FFFF_FFFF) begin
			sat = 1'b1;
			return 48'sh7FFF_FFFF_FFFF;
		end
		if (sum < -64'sh0000_8000_0000_0000) begin
			sat = 1'b1;
			return 48'sh8000_0000_0000;
		end
		return sum[47:0];
	endfunction

	task automatic accumulate_beat(input cmd_t c);
		logic signed [63:0] ex, ey, ez, fx, fy, fz;
		logic s;
		case (c.kind)
			REQ_LOAD: begin
				vx[c.ia] = c.cx;
				vy[c.ia] = c.cy;
				vz[c.ia] = c.cz;
			end
			REQ_CLEAR: begin
				ax[c.ia] = '0;
				ay[c.ia] = '0;
				az[c.ia] = '0;
				asat[c.ia] = 1'b0;
			end
			REQ_TRI: begin
				ex = 64'(vx[c.ib]) - 64'(vx[c.ia]);
				ey = 64'(vy[c.ib]) - 64'(vy[c.ia]);
				ez = 64'(vz[c.ib]) - 64'(vz[c.ia]);
				fx = 64'(vx[c.ic]) - 64'(vx[c.ia]);
				fy = 64'(vy[c.ic]) - 64'(vy[c.ia]);
				fz = 64'(vz[c.ic]) - 64'(vz[c.ia]);
				s = asat[c.ia];
				ax[c.ia] = clamp_add(ax[c.ia], ey * fz - ez * fy, s);
				ay[c.ia] = clamp_add(ay[c.ia], ez * fx - ex * fz, s);
				az[c.ia] = clamp_add(az[c.ia], ex * fy - ey * fx, s);
				asat[c.ia] = s;
			end
			default: begin
				expected_normals.push_back({ax[c.ia], ay[c.ia], az[c.ia], asat[c.ia]});
			end
		endcase
	endtask

	// Queueing helpers; only triangles over loaded vertices are issued.
	function automatic cmd_t make_beat(input req_kind_t k, input int a, input int b,
			input int c, input int x, input int y, input int z);
		cmd_t m;
		m.kind = k;
		m.ia = a[9:0];
		m.ib = b[9:0];
		m.ic = c[9:0];
		m.cx = x[15:0];
		m.cy = y[15:0];
		m.cz = z[15:0];
		if (k == REQ_LOAD)
			vloaded[m.ia] = 1'b1;
		return m;
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return 32767 - $urandom_range(0, 3);
			1: return -32768 + $urandom_range(0, 3);
			default: return $urandom_range(0, 65535) - 32768;
		endcase
	endfunction

	function automatic int loaded_index();
		int i;
		do i = $urandom_range(0, NVERT - 1); while (!vloaded[i]);
		return i;
	endfunction

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= '0;
			req.first_index <= '0;
			req.second_index <= '0;
			req.third_index <= '0;
			req.coord_x <= '0;
			req.coord_y <= '0;
			req.coord_z <= '0;
		end else if (!req.valid || req.ready) begin
			if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cmd_t c;
				c = pending_beats.pop_front();
				accumulate_beat(c);
				req.valid <= 1'b1;
				req.req_type <= c.kind;
				req.first_index <= c.ia;
				req.second_index <= c.ib;
				req.third_index <= c.ic;
				req.coord_x <= c.cx;
				req.coord_y <= c.cy;
				req.coord_z <= c.cz;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Receiver ready, with an optional long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (rsp.valid && rsp.ready) begin
				if (expected_normals.size() == 0) begin
					$error("result beat with no read outstanding");
					errors = errors + 1;
				end else begin
					normal_t e;
					e = expected_normals.pop_front();
					if (rsp.normal_x !== e.nx) begin
						$error("normal_x expected %0d actual %0d", e.nx, rsp.normal_x);
						errors = errors + 1;
					end
					if (rsp.normal_y !== e.ny) begin
						$error("normal_y expected %0d actual %0d", e.ny, rsp.normal_y);
						errors = errors + 1;
					end
					if (rsp.normal_z !== e.nz) begin
						$error("normal_z expected %0d actual %0d", e.nz, rsp.normal_z);
						errors = errors + 1;
					end
					if (rsp.saturated !== e.sat) begin
						$error("saturated expected %0b actual %0b", e.sat, rsp.saturated);
						errors = errors + 1;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pending_beats.size() != 0 || req.valid || expected_normals.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int count);
		int n, a, k;
		for (n = 0; n < count; n++) begin
			k = $urandom_range(0, 99);
			if (k < 20) begin
				pending_beats.push_back(make_beat(REQ_LOAD, $urandom_range(0, NVERT - 1),
					$urandom_range(0, NVERT - 1), $urandom_range(0, NVERT - 1),
					rand_coord(), rand_coord(), rand_coord()));
			end else if (k < 25) begin
				pending_beats.push_back(make_beat(REQ_CLEAR, $urandom_range(0, NVERT - 1),
					$urandom_range(0, NVERT - 1), $urandom_range(0, NVERT - 1),
					$urandom, $urandom, $urandom));
			end else if (k < 65) begin
				// Focus on a small set of corners so sums grow large.
				a = (k < 45) ? $urandom_range(0, 7) : loaded_index();
				if (!vloaded[a]) a = loaded_index();
				pending_beats.push_back(make_beat(REQ_TRI, a, loaded_index(),
					($urandom_range(0, 9) == 0) ? a : loaded_index(), $urandom, $urandom,
					$urandom));
			end else begin
				a = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7)
					: $urandom_range(0, NVERT - 1);
				pending_beats.push_back(make_beat(REQ_READ, a, $urandom_range(0, NVERT - 1),
					$urandom_range(0, NVERT - 1), $urandom, $urandom, $urandom));
			end
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < NVERT; i++) begin
			vloaded[i] = 1'b0;
			vx[i] = '0; vy[i] = '0; vz[i] = '0;
			ax[i] = '0; ay[i] = '0; az[i] = '0;
			asat[i] = 1'b0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, degenerate triangle, large sums, clear, index ends.
		pending_beats.push_back(make_beat(REQ_READ, 1023, 0, 0, 0, 0, 0));
		pending_beats.push_back(make_beat(REQ_LOAD, 0, 0, 0, -32768, -32768, -32768));
		pending_beats.push_back(make_beat(REQ_LOAD, 1, 0, 0, 32767, -32768, 32767));
		pending_beats.push_back(make_beat(REQ_LOAD, 2, 0, 0, -32768, 32767, 32767));
		pending_beats.push_back(make_beat(REQ_LOAD, 1023, 1023, 1023, 32767, 32767, -32768));
		for (i = 0; i < 8; i++)
			pending_beats.push_back(make_beat(REQ_TRI, 0, 1, 2, 0, 0, 0));
		pending_beats.push_back(make_beat(REQ_READ, 0, 0, 0, 0, 0, 0));
		pending_beats.push_back(make_beat(REQ_TRI, 1023, 1023, 1, 0, 0, 0));
		pending_beats.push_back(make_beat(REQ_TRI, 1023, 0, 2, 0, 0, 0));
		pending_beats.push_back(make_beat(REQ_READ, 1023, 1023, 1023, -1, -1, -1));
		pending_beats.push_back(make_beat(REQ_CLEAR, 0, 1023, 1023, -1, -1, -1));
		pending_beats.push_back(make_beat(REQ_READ, 0, 0, 0, 0, 0, 0));
		for (i = 3; i < 8; i++)
			pending_beats.push_back(make_beat(REQ_LOAD, i, 0, 0, rand_coord(), rand_coord(),
				rand_coord()));
		wait_drained();

		// Pressure: receiver holds off while the sender keeps offering reads.
		hold_off = 200;
		for (i = 0; i < 12; i++)
			pending_beats.push_back(make_beat(REQ_READ, i % 8, 0, 0, 0, 0, 0));
		wait_drained();

		random_phase(550);
		wait_drained();
		send_idle_pct = 61;
		recv_idle_pct = 27;
		random_phase(550);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(550);
		wait_drained();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: mesh_face_normal_accumulator_unit.f
src/mfna_pkg.sv
src/mfna_if.sv
src/mfna_front.sv
src/mfna_back.sv
src/mesh_face_normal_accumulator_unit.sv
verif/testbench.sv
